// ===== sv/rsas_pkg.sv =====
// rsas_pkg: shared constants and types for the rotated sorted array search core
// no dependencies; used by the interfaces, the engine, the config block and the top level
package rsas_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 11;
    localparam int WORD_W      = 32;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [PADDR_W-3:0] REG_ELEMENT_COUNT = '0;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

endpackage

// ===== sv/rsas_chan_if.sv =====
// rsas_in_if and rsas_out_if: valid/ready channels for request and response beats
// depends on rsas_pkg
interface rsas_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic [rsas_pkg::IDX_W-1:0]           entry_index;
    logic signed [rsas_pkg::WORD_W-1:0]   value;

    modport source (output valid, output opcode, output entry_index, output value,
                    input ready);
    modport sink   (input valid, input opcode, input entry_index, input value,
                    output ready);
endinterface

interface rsas_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [rsas_pkg::IDX_W-1:0]   position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

// ===== sv/rsas_ram.sv =====
// rsas_ram: generic single-port synchronous ram with a registered read
// no dependencies
module rsas_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== sv/rsas_cfg.sv =====
// rsas_cfg: apb register block holding element_count
// depends on rsas_pkg
module rsas_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsas_pkg::PADDR_W-1:0]        paddr,
    input  logic [rsas_pkg::PDATA_W-1:0]        pwdata,
    output logic [rsas_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [rsas_pkg::COUNT_W-1:0]        element_count
);

    logic [rsas_pkg::COUNT_W-1:0] count_reg;
    logic [rsas_pkg::COUNT_W-1:0] count_next;
    logic                         hit_count;

    assign pready        = 1'b1;
    assign element_count = count_reg;
    assign hit_count     = (paddr[rsas_pkg::PADDR_W-1:2] == rsas_pkg::REG_ELEMENT_COUNT);

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && pready && hit_count)
        begin
            count_next = pwdata[rsas_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit_count)
        begin
            prdata = rsas_pkg::PDATA_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= rsas_pkg::COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/rsas_engine.sv =====
// rsas_engine: sequencer for table loads and the two binary searches
// depends on rsas_pkg and the channel interfaces; drives the table ram
module rsas_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rsas_pkg::COUNT_W-1:0]    element_count,
    rsas_in_if.sink                         request,
    rsas_out_if.source                      response,
    output rsas_pkg::mem_req_t              mem_req,
    input  logic [rsas_pkg::WORD_W-1:0]     mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT_LOAD,
        S_ROT_PROBE,
        S_ROT_CMP,
        S_SRCH_PROBE,
        S_SRCH_CMP,
        S_DONE
    } state_t;

    localparam logic [rsas_pkg::COUNT_W-1:0] DEPTH_C = rsas_pkg::COUNT_W'(rsas_pkg::TABLE_DEPTH);

    state_t                              state_reg, state_next;
    logic [rsas_pkg::COUNT_W-1:0]        n_reg, n_next;
    logic [rsas_pkg::COUNT_W-1:0]        lo_reg, lo_next;
    logic [rsas_pkg::COUNT_W-1:0]        hi_reg, hi_next;
    logic [rsas_pkg::COUNT_W-1:0]        mid_reg, mid_next;
    logic [rsas_pkg::COUNT_W-1:0]        rot_reg, rot_next;
    logic [rsas_pkg::COUNT_W-1:0]        phys_reg, phys_next;
    logic signed [rsas_pkg::WORD_W-1:0]  key_reg, key_next;
    logic signed [rsas_pkg::WORD_W-1:0]  hi_word_reg, hi_word_next;
    logic                                hit_reg, hit_next;
    logic                                resp_valid_reg, resp_valid_next;
    logic                                resp_found_reg, resp_found_next;
    logic [rsas_pkg::IDX_W-1:0]          resp_position_reg, resp_position_next;

    logic [rsas_pkg::COUNT_W-1:0]        n_sat;
    logic [rsas_pkg::COUNT_W-1:0]        mid_c;
    logic [rsas_pkg::COUNT_W:0]          phys_sum;
    logic [rsas_pkg::COUNT_W:0]          phys_wrap;
    logic [rsas_pkg::COUNT_W-1:0]        phys_c;
    logic signed [rsas_pkg::WORD_W-1:0]  word;

    assign request.ready     = (state_reg == S_IDLE);
    assign response.valid    = resp_valid_reg;
    assign response.found    = resp_found_reg;
    assign response.position = resp_position_reg;

    assign n_sat     = (element_count > DEPTH_C) ? DEPTH_C : element_count;
    assign mid_c     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign phys_sum  = {1'b0, rot_reg} + {1'b0, mid_c};
    assign phys_wrap = (phys_sum >= {1'b0, n_reg}) ? (phys_sum - {1'b0, n_reg}) : phys_sum;
    assign phys_c    = phys_wrap[rsas_pkg::COUNT_W-1:0];
    assign word      = $signed(mem_rdata);

    always_comb
    begin
        state_next         = state_reg;
        n_next             = n_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        mid_next           = mid_reg;
        rot_next           = rot_reg;
        phys_next          = phys_reg;
        key_next           = key_reg;
        hi_word_next       = hi_word_reg;
        hit_next           = hit_reg;
        resp_found_next    = resp_found_reg;
        resp_position_next = resp_position_reg;
        resp_valid_next    = resp_valid_reg && !response.ready;
        mem_req            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    if (request.opcode == rsas_pkg::OP_LOAD)
                    begin
                        if ({1'b0, request.entry_index} < DEPTH_C)
                        begin
                            mem_req.en    = 1'b1;
                            mem_req.we    = 1'b1;
                            mem_req.addr  = request.entry_index;
                            mem_req.wdata = request.value;
                        end
                    end
                    else
                    begin
                        key_next = request.value;
                        n_next   = n_sat;
                        hit_next = 1'b0;
                        lo_next  = '0;
                        hi_next  = n_sat - 1'b1;
                        if (n_sat == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = hi_next[rsas_pkg::IDX_W-1:0];
                            state_next   = S_ROT_LOAD;
                        end
                    end
                end
            end
            S_ROT_LOAD:
            begin
                hi_word_next = word;
                state_next   = S_ROT_PROBE;
            end
            S_ROT_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next     = mid_c;
                    mem_req.en   = 1'b1;
                    mem_req.addr = mid_c[rsas_pkg::IDX_W-1:0];
                    state_next   = S_ROT_CMP;
                end
                else
                begin
                    rot_next   = lo_reg;
                    lo_next    = '0;
                    hi_next    = n_reg;
                    state_next = S_SRCH_PROBE;
                end
            end
            S_ROT_CMP:
            begin
                if (hi_word_reg < word)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next      = mid_reg;
                    hi_word_next = word;
                end
                state_next = S_ROT_PROBE;
            end
            S_SRCH_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next     = mid_c;
                    phys_next    = phys_c;
                    mem_req.en   = 1'b1;
                    mem_req.addr = phys_c[rsas_pkg::IDX_W-1:0];
                    state_next   = S_SRCH_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SRCH_CMP:
            begin
                if (key_reg < word)
                begin
                    hi_next    = mid_reg;
                    state_next = S_SRCH_PROBE;
                end
                else if (word < key_reg)
                begin
                    lo_next    = mid_reg + 1'b1;
                    state_next = S_SRCH_PROBE;
                end
                else
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!resp_valid_reg || response.ready)
                begin
                    resp_valid_next    = 1'b1;
                    resp_found_next    = hit_reg;
                    resp_position_next = hit_reg ? phys_reg[rsas_pkg::IDX_W-1:0] : '0;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            resp_valid_reg    <= 1'b0;
            resp_found_reg    <= 1'b0;
            resp_position_reg <= '0;
            n_reg             <= '0;
            lo_reg            <= '0;
            hi_reg            <= '0;
            mid_reg           <= '0;
            rot_reg           <= '0;
            phys_reg          <= '0;
            key_reg           <= '0;
            hi_word_reg       <= '0;
            hit_reg           <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            resp_valid_reg    <= resp_valid_next;
            resp_found_reg    <= resp_found_next;
            resp_position_reg <= resp_position_next;
            n_reg             <= n_next;
            lo_reg            <= lo_next;
            hi_reg            <= hi_next;
            mid_reg           <= mid_next;
            rot_reg           <= rot_next;
            phys_reg          <= phys_next;
            key_reg           <= key_next;
            hi_word_reg       <= hi_word_next;
            hit_reg           <= hit_next;
        end
    end

endmodule

// ===== sv/rotated_sorted_array_search_core.sv =====
// rotated_sorted_array_search_core: load beats give no response
// search beats run the rotation probes and then the key probes before the response; one search
// at a time, one ram read per probe with a registered read; the next beat is taken while
// a response waits to drain
// rst_n is asynchronous active low: control clears at once, element_count returns to 1024
// the table holds no reset value and needs no clearing pass
module rotated_sorted_array_search_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rsas_pkg::PADDR_W-1:0]    paddr,
    input  logic [rsas_pkg::PDATA_W-1:0]    pwdata,
    output logic [rsas_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    rsas_in_if.sink                         request,
    rsas_out_if.source                      response
);

    logic [rsas_pkg::COUNT_W-1:0] element_count;
    rsas_pkg::mem_req_t           mem_req;
    logic [rsas_pkg::WORD_W-1:0]  mem_rdata;

    rsas_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .element_count (element_count)
    );

    rsas_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_count (element_count),
        .request       (request),
        .response      (response),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata)
    );

    rsas_ram #(
        .DEPTH  (rsas_pkg::TABLE_DEPTH),
        .WIDTH  (rsas_pkg::WORD_W),
        .ADDR_W (rsas_pkg::IDX_W)
    ) u_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

`ifndef ASSERT_OFF
    // table writes only come from an accepted load beat
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (request.valid && request.ready
                        && (request.opcode == rsas_pkg::OP_LOAD)))
    else $error("table write without a load beat");

    // ram accesses during a search are reads only
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.en && !request.ready) |-> !mem_req.we)
    else $error("table write during a search");

    // a miss reports position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && !response.found) |-> (response.position == '0))
    else $error("miss with nonzero position");

    // a new response only appears after the engine finishes and returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(response.valid) |-> request.ready)
    else $error("response raised while engine busy");
`endif

endmodule

// ===== dv/rsas_search_checker.sv =====
// rsas_search_checker: watches the config port and both beat channels, predicts each search
// answer from its own copy of the table and compares it with the response; depends on rsas_pkg
// and the channel interfaces in rsas_chan_if.sv
`timescale 1ns / 1ps
module rsas_search_checker
    import rsas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    rsas_in_if                 req,
    rsas_out_if                rsp,
    output int                 fail_count,
    output int                 outstanding,
    output int                 search_count,
    output int                 hit_count,
    output int                 load_count
);

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } answer_t;

    logic signed [WORD_W-1:0] table_words [TABLE_DEPTH];
    logic [COUNT_W-1:0]       active_count;
    answer_t                  expected_answers [$];

    task automatic report_mismatch(string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic int rotation_point(int n);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n - 1;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (table_words[hi] < table_words[mid])
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic answer_t lookup(logic signed [WORD_W-1:0] key);
        answer_t ans;
        int      n;
        int      rot;
        int      lo;
        int      hi;
        int      mid;
        int      phys;
        ans = '0;
        n = int'(active_count);
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        if (n == 0)
            return ans;
        rot = rotation_point(n);
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            phys = rot + mid;
            if (phys >= n)
                phys -= n;
            if (key < table_words[phys])
                hi = mid;
            else if (table_words[phys] < key)
                lo = mid + 1;
            else
            begin
                ans.found = 1'b1;
                ans.position = IDX_W'(phys);
                break;
            end
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        if (!rst_n)
        begin
            active_count = COUNT_RESET;
            expected_answers.delete();
            fail_count = 0;
            search_count = 0;
            hit_count = 0;
            load_count = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_ELEMENT_COUNT)
            begin
                if (pwrite)
                    active_count = pwdata[COUNT_W-1:0];
                else if (prdata !== PDATA_W'(active_count))
                    report_mismatch($sformatf("element_count read %0d, holds %0d",
                                              prdata, active_count));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("response beat with no search waiting");
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp.found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  rsp.found, want.found));
                    if (rsp.position !== want.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  rsp.position, want.position));
                    if (want.found)
                        hit_count++;
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.opcode == OP_LOAD)
                begin
                    table_words[req.entry_index] = req.value;
                    load_count++;
                end
                else
                begin
                    expected_answers.push_back(lookup(req.value));
                    search_count++;
                end
            end
        end
        outstanding = expected_answers.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// tb_top: drives load and search beats and config writes into rotated_sorted_array_search_core
// under changing idle and stall patterns; rsas_search_checker predicts and compares the answers
// depends on rsas_pkg, rsas_chan_if.sv, rsas_search_checker.sv and the core
`timescale 1ns / 1ps
module tb_top;
    import rsas_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TARGET_BEATS    = 1900;

    localparam logic [PADDR_W-1:0]       COUNT_ADDR = {REG_ELEMENT_COUNT, 2'b00};
    localparam logic signed [WORD_W-1:0] WORD_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN   = 32'sh8000_0000;
    localparam longint                   WIDE_MIN   = -64'sh8000_0000;

    typedef enum {FILL_ROTATED, FILL_SORTED, FILL_NOISE} fill_kind_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rsas_in_if  req_if ();
    rsas_out_if rsp_if ();

    int   fail_count;
    int   outstanding;
    int   search_count;
    int   hit_count;
    int   load_count;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   beats_sent     = 0;
    int   table_fills    = 0;
    int   count_writes   = 0;
    int   cycles         = 0;
    bit   holding        = 1'b0;
    event hold_off_go;

    logic signed [WORD_W-1:0] shadow [TABLE_DEPTH];

    rotated_sorted_array_search_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .request  (req_if),
        .response (rsp_if)
    );

    rsas_search_checker answer_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .req          (req_if),
        .rsp          (rsp_if),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .search_count (search_count),
        .hit_count    (hit_count),
        .load_count   (load_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb_top NOT OK");
        $finish;
    end

    always @(negedge clk)
    begin
        if (holding)
            rsp_if.ready = 1'b0;
        else
            rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always
    begin
        @(hold_off_go);
        holding = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        holding = 1'b0;
    end

    task automatic set_idle(int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(logic write, logic [PDATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = write;
        paddr = COUNT_ADDR;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_count(int n);
        wait_idle();
        apb_access(1'b1, PDATA_W'(n));
        count_writes++;
    endtask

    task automatic send_beat(logic op, logic [IDX_W-1:0] idx, logic signed [WORD_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.opcode = op;
        req_if.entry_index = idx;
        req_if.value = val;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
        req_if.valid = 1'b0;
        beats_sent++;
    endtask

    task automatic load_word(int idx, logic signed [WORD_W-1:0] val);
        send_beat(OP_LOAD, IDX_W'(idx), val);
        shadow[idx] = val;
    endtask

    task automatic search_key(logic signed [WORD_W-1:0] key);
        send_beat(OP_SEARCH, IDX_W'($urandom), key);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_key(int n);
        logic signed [WORD_W-1:0] w;
        w = shadow[$urandom_range(n - 1)];
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return w;
            5, 6:          return w + 1;
            7:             return w - 1;
            8:             return $urandom;
            default:       return $urandom_range(1) ? WORD_MIN : WORD_MAX;
        endcase
    endfunction

    task automatic fill_table(int n, fill_kind_t kind);
        longint                   span;
        int                       rot;
        logic signed [WORD_W-1:0] w;
        span = 64'sd4294967296 / n;
        rot = (kind == FILL_ROTATED) ? $urandom_range(n - 1) : 0;
        for (int i = 0; i < n; i++)
        begin
            if (kind == FILL_NOISE)
                w = ($urandom_range(3) == 0) ? WORD_W'($urandom_range(7)) : WORD_W'($urandom);
            else
                w = WORD_W'(WIDE_MIN + longint'(i) * span + $urandom_range(32'(span - 1)));
            load_word((i + rot) % n, w);
        end
        table_fills++;
    endtask

    // mostly searches, with a stray load now and then that breaks the ordering
    task automatic search_phase(int n, int searches);
        for (int k = 0; k < searches; k++)
        begin
            if ($urandom_range(19) == 0)
                load_word($urandom_range(n - 1), pick_key(n));
            else
                search_key(pick_key(n));
        end
    endtask

    initial
    begin
        int         n;
        int         phase;
        fill_kind_t kind;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.opcode = OP_LOAD;
        req_if.entry_index = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset readback, extremes, single entry, zero count, unrotated table
        set_idle(0);
        apb_access(1'b0, '0);
        set_count(4);
        load_word(0, WORD_MAX);
        load_word(1, WORD_MIN);
        load_word(2, 0);
        load_word(3, 5);
        search_key(WORD_MIN);
        search_key(WORD_MAX);
        search_key(0);
        search_key(5);
        search_key(1);
        search_key(-1);
        search_key(6);
        set_count(1);
        search_key(WORD_MAX);
        search_key(WORD_MIN);
        set_count(0);
        search_key(0);
        search_key(WORD_MAX);
        set_count(4);
        load_word(0, WORD_MIN);
        load_word(1, -1);
        load_word(2, 0);
        load_word(3, WORD_MAX);
        search_key(WORD_MAX);
        search_key(WORD_MIN);
        search_key(-1);

        // full table, long receiver hold-off, then counts above the table depth
        set_idle(3);
        set_count(TABLE_DEPTH);
        apb_access(1'b0, '0);
        fill_table(TABLE_DEPTH, FILL_ROTATED);
        -> hold_off_go;
        search_phase(TABLE_DEPTH, 40);
        set_idle(2);
        set_count(2047);
        apb_access(1'b0, '0);
        search_phase(TABLE_DEPTH, 20);
        set_count(TABLE_DEPTH + 1);
        search_phase(TABLE_DEPTH, 10);

        phase = 0;
        while (beats_sent < TARGET_BEATS)
        begin
            set_idle(phase % 4);
            n = ($urandom_range(9) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 24);
            // keep the last phase close to the beat budget
            if (3 * n > TARGET_BEATS - beats_sent)
                n = (TARGET_BEATS - beats_sent) / 3 + 1;
            case ($urandom_range(19))
                0, 1, 2: kind = FILL_SORTED;
                3, 4, 5: kind = FILL_NOISE;
                default: kind = FILL_ROTATED;
            endcase
            set_count(n);
            fill_table(n, kind);
            search_phase(n, $urandom_range(n + 4, 2 * n + 12));
            if ($urandom_range(3) == 0)
            begin
                n = $urandom_range(1, n);
                set_count(n);
                search_phase(n, $urandom_range(4, 16));
            end
            phase++;
        end

        set_idle(0);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d beats: %0d loads, %0d searches with %0d hits", beats_sent,
                 load_count, search_count, hit_count);
        $display("%0d table fills across %0d element_count writes, %0d cycles", table_fills,
                 count_writes, cycles);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rsas_pkg.sv
sv/rsas_chan_if.sv
sv/rsas_ram.sv
sv/rsas_cfg.sv
sv/rsas_engine.sv
sv/rotated_sorted_array_search_core.sv
dv/rsas_search_checker.sv
dv/tb_top.sv
